FILE: rtl/tssf_pkg.sv
// Shared types, constants and register codes for the tensor slice stream filter.
package tssf_pkg;

    localparam int MAX_DIMS   = 4;
    localparam int DIM_BITS   = 16;
    localparam int DATA_BITS  = 32;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int CFG_BITS   = 64;
    localparam int PACK_BITS  = MAX_DIMS * DIM_BITS;
    localparam int BOUND_BITS = DIM_BITS + 2;

    typedef logic [DIM_BITS-1:0]            coord_t;
    typedef coord_t [MAX_DIMS-1:0]          coord_vec_t;
    typedef logic signed [BOUND_BITS-1:0]   bound_t;

    typedef struct packed {
        bound_t lo;
        bound_t hi;
    } dim_range_t;

    typedef dim_range_t [MAX_DIMS-1:0]      range_vec_t;

    typedef struct packed {
        logic keep;
        logic last;
    } slice_flags_t;

    typedef enum logic [1:0] {
        CFG_DIM_SIZES    = 2'd0,
        CFG_SLICE_STARTS = 2'd1,
        CFG_SLICE_ENDS   = 2'd2,
        CFG_SLICED_MASK  = 2'd3
    } cfg_idx_t;

endpackage

FILE: rtl/tssf_range_calc.sv
// Effective start/end bounds of one dimension from its size and slice fields.
module tssf_range_calc
    import tssf_pkg::*;
(
    input  coord_t             size,
    input  logic [DIM_BITS-1:0] start_raw,
    input  logic [DIM_BITS-1:0] end_raw,
    input  logic               sliced,
    output dim_range_t         bounds
);

    bound_t size_x;
    bound_t start_x;
    bound_t end_x;
    bound_t start_adj;
    bound_t end_adj;
    bound_t start_clamp;
    bound_t end_clamp;

    always_comb
    begin
        size_x  = $signed({2'b00, size});
        start_x = $signed({{2{start_raw[DIM_BITS-1]}}, start_raw});
        end_x   = $signed({{2{end_raw[DIM_BITS-1]}}, end_raw});

        // Negative positions count back from the size
        start_adj = start_x[BOUND_BITS-1] ? (start_x + size_x) : start_x;
        end_adj   = end_x[BOUND_BITS-1]   ? (end_x + size_x)   : end_x;

        start_clamp = start_adj[BOUND_BITS-1] ? '0 : start_adj;
        end_clamp   = end_adj[BOUND_BITS-1]   ? '0 : end_adj;
        if (end_clamp > size_x)
        begin
            end_clamp = size_x;
        end

        if (sliced)
        begin
            bounds.lo = start_clamp;
            bounds.hi = end_clamp;
        end
        else
        begin
            bounds.lo = '0;
            bounds.hi = size_x;
        end
    end

endmodule

FILE: rtl/tssf_coord_counter.sv
// Row-major coordinate counters, innermost dimension first with carry outward.
module tssf_coord_counter
    import tssf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  coord_vec_t sizes,
    output coord_vec_t coords
);

    coord_vec_t            coord_reg;
    coord_vec_t            coord_next;
    logic [MAX_DIMS-1:0]   wrap;
    logic [MAX_DIMS:0]     carry;
    logic [DIM_BITS:0]     inc;

    always_comb
    begin
        inc        = '0;
        coord_next = coord_reg;
        carry[MAX_DIMS] = advance;
        for (int k = MAX_DIMS - 1; k >= 0; k--)
        begin
            inc     = {1'b0, coord_reg[k]} + {{DIM_BITS{1'b0}}, 1'b1};
            wrap[k] = (inc >= {1'b0, sizes[k]});
            if (carry[k+1])
            begin
                coord_next[k] = wrap[k] ? '0 : inc[DIM_BITS-1:0];
            end
            carry[k] = carry[k+1] & wrap[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_reg <= '0;
        end
        else
        begin
            coord_reg <= coord_next;
        end
    end

    assign coords = coord_reg;

endmodule

FILE: rtl/tssf_slice_check.sv
// Window test of one coordinate set: inside every range, and at every range end.
module tssf_slice_check
    import tssf_pkg::*;
(
    input  coord_vec_t   coords,
    input  range_vec_t   ranges,
    output slice_flags_t flags
);

    bound_t c_x;

    always_comb
    begin
        c_x        = '0;
        flags.keep = 1'b1;
        flags.last = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            c_x = $signed({2'b00, coords[d]});
            if (!((c_x >= ranges[d].lo) && (c_x < ranges[d].hi)))
            begin
                flags.keep = 1'b0;
            end
            if (c_x != (ranges[d].hi - bound_t'(1)))
            begin
                flags.last = 1'b0;
            end
        end
    end

endmodule

FILE: rtl/tensor_slice_stream_filter_unit.sv
// Top level of the tensor slice stream filter: config registers, two-stage beat pipeline.
//
//  Channel   Direction  Signals                              Carries
//  --------  ---------  -----------------------------------  ------------------------------
//  s_axis    in         s_tvalid s_tready s_tdata[31:0]      in_value (bits 31:0)
//  m_axis    out        m_tvalid m_tready m_tdata[31:0]      out_value (bits 31:0)
//                       m_tlast                              out_last
//  cfg       in         cfg_we cfg_index[1:0] cfg_data[63:0] dim_sizes, slice_starts,
//                                                            slice_ends, sliced_mask
//
//  One beat a cycle is taken while s_tready is high. A kept element passes through the
//  input register, where its coordinate snapshot is tested against the slice window,
//  and then through the output register before it appears on m_axis.
//  Reset clears the coordinate counters, the config registers and both valid flags.
//  A stall on m_axis holds the output register; the input register keeps loading
//  while it holds a dropped beat or the output register is free, so s_tready drops
//  only when both stages are full.
module tensor_slice_stream_filter_unit
    import tssf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_BITS-1:0] s_tdata,   // [31:0] in_value
    // master stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_BITS-1:0] m_tdata,   // [31:0] out_value
    output logic                  m_tlast,
    // configuration
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data
);

    // Config registers (only the packed fields are kept)
    logic [PACK_BITS-1:0] dim_sizes_reg;
    logic [PACK_BITS-1:0] slice_starts_reg;
    logic [PACK_BITS-1:0] slice_ends_reg;
    logic [MAX_DIMS-1:0]  sliced_mask_reg;

    coord_vec_t   sizes;
    range_vec_t   ranges;
    coord_vec_t   coords;

    // Input stage
    logic                 s1_valid_reg;
    logic [DATA_BITS-1:0] s1_value_reg;
    coord_vec_t           s1_coord_reg;
    slice_flags_t         s1_flags;
    logic                 s1_fire;
    logic                 in_fire;

    // Output stage
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [TDATA_BITS-1:0] out_value_reg;
    logic                  out_last_reg;
    logic                  out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_sizes_reg    <= '0;
            slice_starts_reg <= '0;
            slice_ends_reg   <= '0;
            sliced_mask_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DIM_SIZES:    dim_sizes_reg    <= cfg_data[PACK_BITS-1:0];
                CFG_SLICE_STARTS: slice_starts_reg <= cfg_data[PACK_BITS-1:0];
                CFG_SLICE_ENDS:   slice_ends_reg   <= cfg_data[PACK_BITS-1:0];
                CFG_SLICED_MASK:  sliced_mask_reg  <= cfg_data[MAX_DIMS-1:0];
                default:          ;
            endcase
        end
    end

    // Dimension 0 sits in the top field of each packed register
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_dim
        localparam int LSB = (MAX_DIMS - 1 - d) * DIM_BITS;

        assign sizes[d] = dim_sizes_reg[LSB +: DIM_BITS];

        tssf_range_calc u_range
        (
            .size      (sizes[d]),
            .start_raw (slice_starts_reg[LSB +: DIM_BITS]),
            .end_raw   (slice_ends_reg[LSB +: DIM_BITS]),
            .sliced    (sliced_mask_reg[d]),
            .bounds    (ranges[d])
        );
    end

    // Handshake: drop beats need no output slot
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_flags.keep || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;

    // Advance the coordinates on every accepted beat
    tssf_coord_counter u_counter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .sizes   (sizes),
        .coords  (coords)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Capture the element with the coordinates it was taken at
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_value_reg <= s_tdata[DATA_BITS-1:0];
            s1_coord_reg <= coords;
        end
    end

    tssf_slice_check u_check
    (
        .coords (s1_coord_reg),
        .ranges (ranges),
        .flags  (s1_flags)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg && s1_flags.keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register only with kept beats; hold it while stalled
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && s1_flags.keep)
        begin
            out_value_reg <= TDATA_BITS'(s1_value_reg);
            out_last_reg  <= s1_flags.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    // A kept beat that leaves the input stage must show up on the output
    a_kept_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_flags.keep && out_free |=> m_tvalid)
        else $error("kept beat lost between stages");

    // Both stages full and stalled: no new beat may be taken
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && s1_valid_reg && s1_flags.keep |-> !s_tready)
        else $error("input accepted while pipeline full");

    // An accepted beat always lands in the input stage
    a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s1_valid_reg)
        else $error("accepted beat not held in input stage");

endmodule
